// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by the active-low reset.
`define JSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, gated by the active-low reset.
`define JSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Condition that must never be seen.
`define JSS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// File: rtl/jss_pkg.sv
// ----------------------------------------------------------------------------
// jss_pkg
// Sizes, policy codes and shared structs of the job schedule simulator.
// ----------------------------------------------------------------------------
`default_nettype none

package jss_pkg;

    localparam int MAX_JOBS   = 16;
    localparam int TIME_WIDTH = 16;
    localparam int FIELD_W    = 16;
    localparam int RES_W      = 21;
    localparam int JOB_IDX_W  = 4;
    localparam int IDX_W      = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W      = $clog2(MAX_JOBS + 1);

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [RES_W-1:0]      res_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // Policy codes; the spare code behaves as first come first served
    localparam logic [1:0] POL_FCFS  = 2'd0;
    localparam logic [1:0] POL_SJF   = 2'd1;
    localparam logic [1:0] POL_SRTF  = 2'd2;
    localparam logic [1:0] POL_SPARE = 2'd3;

    // Write requests into the job store
    typedef struct packed {
        logic  load_we;
        idx_t  load_idx;
        time_t load_arr;
        time_t load_bur;
        logic  rem_we;
        idx_t  rem_idx;
        time_t rem_val;
        logic  res_we;
        idx_t  res_idx;
        res_t  res_wait;
        res_t  res_tat;
    } store_wr_t;

    // Job fields at the scan position
    typedef struct packed {
        time_t arr;
        time_t bur;
        time_t rem;
    } scan_rd_t;

    // Results at the output position
    typedef struct packed {
        res_t wait_t;
        res_t tat;
    } res_rd_t;

endpackage

`default_nettype wire

// File: rtl/jss_job_if.sv
// ----------------------------------------------------------------------------
// jss_job_if
// Job beat channel: arrival, burst and end-of-set mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface jss_job_if;
    logic                             valid;
    logic                             ready;
    logic [jss_pkg::FIELD_W-1:0]      arrival_time;
    logic [jss_pkg::FIELD_W-1:0]      burst_time;
    logic                             last_job;

    modport source (output valid, output arrival_time, output burst_time,
                    output last_job, input ready);
    modport sink   (input valid, input arrival_time, input burst_time,
                    input last_job, output ready);
endinterface

`default_nettype wire

// File: rtl/jss_res_if.sv
// ----------------------------------------------------------------------------
// jss_res_if
// Result beat channel: job index, wait and turnaround times.
// ----------------------------------------------------------------------------
`default_nettype none

interface jss_res_if;
    logic                             valid;
    logic                             ready;
    logic [jss_pkg::JOB_IDX_W-1:0]    job_index;
    logic [jss_pkg::RES_W-1:0]        wait_time;
    logic [jss_pkg::RES_W-1:0]        turnaround_time;
    logic                             last_result;

    modport source (output valid, output job_index, output wait_time,
                    output turnaround_time, output last_result, input ready);
    modport sink   (input valid, input job_index, input wait_time,
                    input turnaround_time, input last_result, output ready);
endinterface

`default_nettype wire

// File: rtl/jss_store.sv
// ----------------------------------------------------------------------------
// jss_store
// Per-job register file: arrival, burst, remaining time and results.
// ----------------------------------------------------------------------------
`default_nettype none

module jss_store (
    input  wire logic                clk,
    input  wire jss_pkg::store_wr_t  wr,
    input  wire jss_pkg::idx_t       scan_idx,
    input  wire jss_pkg::idx_t       out_idx,
    output jss_pkg::scan_rd_t        scan_rd,
    output jss_pkg::res_rd_t         res_rd
);

    jss_pkg::time_t arr_mem_reg  [jss_pkg::MAX_JOBS];
    jss_pkg::time_t bur_mem_reg  [jss_pkg::MAX_JOBS];
    jss_pkg::time_t rem_mem_reg  [jss_pkg::MAX_JOBS];
    jss_pkg::res_t  wait_mem_reg [jss_pkg::MAX_JOBS];
    jss_pkg::res_t  tat_mem_reg  [jss_pkg::MAX_JOBS];

    // Load a job; remaining time starts at the burst
    always_ff @(posedge clk)
    begin
        if (wr.load_we)
        begin
            arr_mem_reg[wr.load_idx] <= wr.load_arr;
            bur_mem_reg[wr.load_idx] <= wr.load_bur;
        end
        if (wr.load_we)
        begin
            rem_mem_reg[wr.load_idx] <= wr.load_bur;
        end
        else if (wr.rem_we)
        begin
            rem_mem_reg[wr.rem_idx] <= wr.rem_val;
        end
        if (wr.res_we)
        begin
            wait_mem_reg[wr.res_idx] <= wr.res_wait;
            tat_mem_reg[wr.res_idx]  <= wr.res_tat;
        end
    end

    // Read the scan position and the output position
    always_comb
    begin
        scan_rd.arr   = arr_mem_reg[scan_idx];
        scan_rd.bur   = bur_mem_reg[scan_idx];
        scan_rd.rem   = rem_mem_reg[scan_idx];
        res_rd.wait_t = wait_mem_reg[out_idx];
        res_rd.tat    = tat_mem_reg[out_idx];
    end

endmodule

`default_nettype wire

// File: rtl/jss_core.sv
// ----------------------------------------------------------------------------
// jss_core
// Load sequencer, one-job-per-cycle scan unit and scheduling step logic.
// ----------------------------------------------------------------------------
`default_nettype none

module jss_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    jss_job_if.sink                 in_job,
    jss_res_if.source               out_res,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_wdata,
    input  wire jss_pkg::scan_rd_t  scan_rd,
    input  wire jss_pkg::res_rd_t   res_rd,
    output jss_pkg::store_wr_t      wr,
    output jss_pkg::idx_t           scan_idx,
    output jss_pkg::idx_t           out_idx
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_EXEC,
        ST_RETIRE,
        ST_OUT_FETCH,
        ST_OUT_SEND
    } state_t;

    state_t                      state_reg;
    logic [1:0]                  pol_reg;
    jss_pkg::cnt_t               count_reg;
    jss_pkg::cnt_t               completed_reg;
    jss_pkg::res_t               clock_reg;
    logic [jss_pkg::MAX_JOBS-1:0] done_reg;
    jss_pkg::idx_t               scan_reg;
    jss_pkg::idx_t               oidx_reg;

    logic                        best_vld_reg;
    jss_pkg::idx_t               best_idx_reg;
    jss_pkg::time_t              best_key_reg;
    jss_pkg::time_t              best_arr_reg;
    jss_pkg::time_t              best_bur_reg;
    jss_pkg::time_t              best_rem_reg;
    logic                        min_vld_reg;
    jss_pkg::time_t              min_arr_reg;
    logic                        nxt_vld_reg;
    jss_pkg::time_t              nxt_arr_reg;
    jss_pkg::time_t              run_reg;

    logic                        out_valid_reg;
    jss_pkg::idx_t               out_idx_reg;
    jss_pkg::res_t               out_wait_reg;
    jss_pkg::res_t               out_tat_reg;
    logic                        out_last_reg;

    logic                        in_acc;
    logic                        room;
    jss_pkg::time_t              in_arr;
    jss_pkg::time_t              in_bur;
    logic                        scan_last;
    logic                        cur_done;
    logic                        cur_elig;
    jss_pkg::time_t              cur_key;
    logic                        cur_better;
    jss_pkg::res_t               start_time;
    jss_pkg::res_t               gap;
    logic                        preempt;
    jss_pkg::time_t              rem_new;
    jss_pkg::res_t               tat;
    jss_pkg::res_t               wait_val;
    logic                        set_done;
    logic                        out_last_next;

    // Input beat and store load
    assign in_job.ready = (state_reg == ST_LOAD);
    assign in_acc       = in_job.valid && in_job.ready;
    assign room         = (count_reg < jss_pkg::cnt_t'(jss_pkg::MAX_JOBS));
    assign in_arr       = jss_pkg::time_t'(in_job.arrival_time);
    assign in_bur       = (jss_pkg::time_t'(in_job.burst_time) == '0)
                          ? jss_pkg::time_t'(1) : jss_pkg::time_t'(in_job.burst_time);

    // Scan unit: one stored job per cycle
    assign scan_idx   = scan_reg;
    assign scan_last  = (jss_pkg::cnt_t'(scan_reg) == count_reg - jss_pkg::cnt_t'(1));
    assign cur_done   = done_reg[scan_reg];
    assign cur_elig   = !cur_done && ((pol_reg == jss_pkg::POL_FCFS)
                        || (jss_pkg::res_t'(scan_rd.arr) <= clock_reg));

    always_comb
    begin
        unique case (pol_reg)
            jss_pkg::POL_SJF:  cur_key = scan_rd.bur;
            jss_pkg::POL_SRTF: cur_key = scan_rd.rem;
            default:           cur_key = '0;
        endcase
    end

    // Lower key wins, then earlier arrival; equal pairs keep the lower index
    assign cur_better = !best_vld_reg || (cur_key < best_key_reg)
                        || ((cur_key == best_key_reg) && (scan_rd.arr < best_arr_reg));

    // Decision: start time, and run length cut at the next arrival when SRTF preempts
    assign start_time = (jss_pkg::res_t'(best_arr_reg) > clock_reg)
                        ? jss_pkg::res_t'(best_arr_reg) : clock_reg;
    assign gap        = jss_pkg::res_t'(nxt_arr_reg) - clock_reg;
    assign preempt    = (pol_reg == jss_pkg::POL_SRTF) && nxt_vld_reg
                        && (gap < jss_pkg::res_t'(best_rem_reg));

    // Execution and retirement
    assign rem_new  = best_rem_reg - run_reg;
    assign tat      = clock_reg - jss_pkg::res_t'(best_arr_reg);
    assign wait_val = tat - jss_pkg::res_t'(best_bur_reg);
    assign set_done = (completed_reg + jss_pkg::cnt_t'(1) == count_reg);

    // Output fetch
    assign out_idx       = oidx_reg;
    assign out_last_next = (jss_pkg::cnt_t'(oidx_reg) == count_reg - jss_pkg::cnt_t'(1));

    // Store write requests
    always_comb
    begin
        wr          = '0;
        wr.load_we  = in_acc && room;
        wr.load_idx = jss_pkg::idx_t'(count_reg);
        wr.load_arr = in_arr;
        wr.load_bur = in_bur;
        wr.rem_we   = (state_reg == ST_EXEC);
        wr.rem_idx  = best_idx_reg;
        wr.rem_val  = rem_new;
        wr.res_we   = (state_reg == ST_RETIRE);
        wr.res_idx  = best_idx_reg;
        wr.res_wait = wait_val;
        wr.res_tat  = tat;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            pol_reg       <= jss_pkg::POL_FCFS;
            count_reg     <= '0;
            completed_reg <= '0;
            clock_reg     <= '0;
            done_reg      <= '0;
            scan_reg      <= '0;
            oidx_reg      <= '0;
            best_vld_reg  <= 1'b0;
            min_vld_reg   <= 1'b0;
            nxt_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Policy write; the unused code acts as first come first served
            if (cfg_we)
            begin
                pol_reg <= (cfg_wdata == jss_pkg::POL_SPARE) ? jss_pkg::POL_FCFS : cfg_wdata;
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (room)
                        begin
                            count_reg <= count_reg + jss_pkg::cnt_t'(1);
                        end
                        if (in_job.last_job)
                        begin
                            completed_reg <= '0;
                            clock_reg     <= '0;
                            done_reg      <= '0;
                            scan_reg      <= '0;
                            best_vld_reg  <= 1'b0;
                            min_vld_reg   <= 1'b0;
                            nxt_vld_reg   <= 1'b0;
                            state_reg     <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (cur_elig && cur_better)
                    begin
                        best_vld_reg <= 1'b1;
                        best_idx_reg <= scan_reg;
                        best_key_reg <= cur_key;
                        best_arr_reg <= scan_rd.arr;
                        best_bur_reg <= scan_rd.bur;
                        best_rem_reg <= scan_rd.rem;
                    end
                    if (!cur_done && (!min_vld_reg || (scan_rd.arr < min_arr_reg)))
                    begin
                        min_vld_reg <= 1'b1;
                        min_arr_reg <= scan_rd.arr;
                    end
                    if (!cur_done && (jss_pkg::res_t'(scan_rd.arr) > clock_reg)
                        && (!nxt_vld_reg || (scan_rd.arr < nxt_arr_reg)))
                    begin
                        nxt_vld_reg <= 1'b1;
                        nxt_arr_reg <= scan_rd.arr;
                    end
                    if (scan_last)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + jss_pkg::idx_t'(1);
                    end
                end

                ST_DECIDE:
                begin
                    if (!best_vld_reg)
                    begin
                        // Processor idle: jump to the earliest pending arrival
                        clock_reg    <= jss_pkg::res_t'(min_arr_reg);
                        scan_reg     <= '0;
                        min_vld_reg  <= 1'b0;
                        nxt_vld_reg  <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                    else
                    begin
                        clock_reg <= start_time;
                        run_reg   <= preempt ? jss_pkg::time_t'(gap) : best_rem_reg;
                        state_reg <= ST_EXEC;
                    end
                end

                ST_EXEC:
                begin
                    clock_reg    <= clock_reg + jss_pkg::res_t'(run_reg);
                    best_rem_reg <= rem_new;
                    scan_reg     <= '0;
                    best_vld_reg <= 1'b0;
                    min_vld_reg  <= 1'b0;
                    nxt_vld_reg  <= 1'b0;
                    state_reg    <= (rem_new == '0) ? ST_RETIRE : ST_SCAN;
                end

                ST_RETIRE:
                begin
                    done_reg[best_idx_reg] <= 1'b1;
                    completed_reg          <= completed_reg + jss_pkg::cnt_t'(1);
                    oidx_reg               <= '0;
                    state_reg              <= set_done ? ST_OUT_FETCH : ST_SCAN;
                end

                ST_OUT_FETCH:
                begin
                    out_valid_reg <= 1'b1;
                    out_idx_reg   <= oidx_reg;
                    out_wait_reg  <= res_rd.wait_t;
                    out_tat_reg   <= res_rd.tat;
                    out_last_reg  <= out_last_next;
                    state_reg     <= ST_OUT_SEND;
                end

                ST_OUT_SEND:
                begin
                    if (out_res.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            count_reg <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            oidx_reg  <= oidx_reg + jss_pkg::idx_t'(1);
                            state_reg <= ST_OUT_FETCH;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // Drive the result beat
    assign out_res.valid           = out_valid_reg;
    assign out_res.job_index       = jss_pkg::JOB_IDX_W'(out_idx_reg);
    assign out_res.wait_time       = out_wait_reg;
    assign out_res.turnaround_time = out_tat_reg;
    assign out_res.last_result     = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/job_schedule_simulator.sv
// ----------------------------------------------------------------------------
// job_schedule_simulator
// Single-processor scheduling simulator (FCFS, SJF, SRTF) over a loaded job set.
// ----------------------------------------------------------------------------
//
//   channel   dir  beat contents
//   in_job    in   arrival_time, burst_time, last_job
//   out_res   out  job_index, wait_time, turnaround_time, last_result
//   cfg       in   policy_mode on cfg_wdata, written when cfg_we is high
//
// The beat with last_job starts the simulation: every scheduling decision
// scans all n stored jobs, one after another, through one compare unit, then
// decides, runs the chosen job and retires it once its remaining time is zero.
// FCFS/SJF need up to 2n decisions, SRTF up to about 3n; then the results are
// sent one at a time, each held through any stall on out_res. in_job.ready is
// low from the last job until the final result beat is taken. Reset is
// asynchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module job_schedule_simulator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    jss_job_if.sink          in_job,
    jss_res_if.source        out_res,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata
);

    jss_pkg::store_wr_t  wr;
    jss_pkg::scan_rd_t   scan_rd;
    jss_pkg::res_rd_t    res_rd;
    jss_pkg::idx_t       scan_idx;
    jss_pkg::idx_t       out_idx;

    // Sequencer and scan unit
    jss_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_job    (in_job),
        .out_res   (out_res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .scan_rd   (scan_rd),
        .res_rd    (res_rd),
        .wr        (wr),
        .scan_idx  (scan_idx),
        .out_idx   (out_idx)
    );

    // Job register file
    jss_store u_store (
        .clk      (clk),
        .wr       (wr),
        .scan_idx (scan_idx),
        .out_idx  (out_idx),
        .scan_rd  (scan_rd),
        .res_rd   (res_rd)
    );

endmodule

`default_nettype wire

// File: rtl/jss_checker.sv
// ----------------------------------------------------------------------------
// jss_checker
// Port-level checks of the job schedule simulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jss_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic                          in_last,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [jss_pkg::RES_W-1:0]     out_wait,
    input  wire logic [jss_pkg::RES_W-1:0]     out_tat,
    input  wire logic                          out_last
);

    // Input and output sides never overlap in this design
    `JSS_ASSERT_NEVER(a_no_overlap, clk, rst_n, in_ready && out_valid)
    // The last job starts simulation: input closes at once
    `JSS_ASSERT_NEXT(a_close_on_last, clk, rst_n, in_valid && in_ready && in_last, !in_ready)
    // The final result reopens the input
    `JSS_ASSERT_NEXT(a_reopen, clk, rst_n, out_valid && out_ready && out_last, in_ready)
    // Wait never exceeds turnaround
    `JSS_ASSERT_SAME(a_wait_le_tat, clk, rst_n, out_valid, out_wait <= out_tat)
    // A stalled result beat holds
    `JSS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_tat))

endmodule

bind job_schedule_simulator jss_checker u_jss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_job.valid),
    .in_ready  (in_job.ready),
    .in_last   (in_job.last_job),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_wait  (out_res.wait_time),
    .out_tat   (out_res.turnaround_time),
    .out_last  (out_res.last_result)
);

`default_nettype wire
